// ===== src/occupancy_grid_point_rect_marker_unit_macros.svh =====
// Assertion macros for the occupancy grid marker.
// Included by the top level; no other dependencies.
`ifndef OCCUPANCY_GRID_POINT_RECT_MARKER_UNIT_MACROS_SVH
`define OCCUPANCY_GRID_POINT_RECT_MARKER_UNIT_MACROS_SVH

// same-cycle implication
`define OGPRM_ASSERT_NOW(name, clk, rst, ante, cons) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("ogprm: same-cycle check failed");

// next-cycle implication
`define OGPRM_ASSERT_NEXT(name, clk, rst, ante, cons) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("ogprm: next-cycle check failed");

`endif

// ===== src/ogprm_pkg.sv =====
// Shared types, codes and constants for the occupancy grid marker.
// No dependencies.
package ogprm_pkg;

  localparam int DEF_MAX_COLUMNS = 64;
  localparam int DEF_MAX_ROWS    = 64;

  localparam int COORD_W = 16;
  localparam int CFG_W   = 12;
  localparam int DVD_W   = 15;
  localparam int ADDR_W  = 4;
  localparam int DATA_W  = 32;

  localparam logic [CFG_W-1:0] RST_WIN_W  = 12'd640;
  localparam logic [CFG_W-1:0] RST_WIN_H  = 12'd480;
  localparam logic [CFG_W-1:0] RST_CELL_W = 12'd10;
  localparam logic [CFG_W-1:0] RST_CELL_H = 12'd10;

  localparam logic [1:0] KIND_POINT = 2'd0;
  localparam logic [1:0] KIND_RECT  = 2'd1;
  localparam logic [1:0] KIND_QUERY = 2'd2;
  localparam logic [1:0] KIND_NOP   = 2'd3;

  localparam logic [1:0] REG_WIN_W  = 2'd0;
  localparam logic [1:0] REG_WIN_H  = 2'd1;
  localparam logic [1:0] REG_CELL_W = 2'd2;
  localparam logic [1:0] REG_CELL_H = 2'd3;

  typedef struct packed {
    logic [1:0]                 kind;
    logic signed [COORD_W-1:0]  x_first;
    logic signed [COORD_W-1:0]  y_first;
    logic signed [COORD_W-1:0]  x_second;
    logic signed [COORD_W-1:0]  y_second;
  } in_word_t;

  typedef struct packed {
    logic occupied;
    logic status;
  } out_word_t;

  typedef enum logic [2:0] {
    DIV_COLS,
    DIV_ROWS,
    DIV_X0,
    DIV_Y0,
    DIV_X1,
    DIV_Y1
  } div_sel_t;

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_DIV_COLS,
    ST_DIV_ROWS,
    ST_IDLE,
    ST_DIV_X0,
    ST_DIV_Y0,
    ST_DIV_X1,
    ST_DIV_Y1,
    ST_CHECK,
    ST_FILL,
    ST_FILL_END,
    ST_RESULT
  } state_t;

  typedef struct packed {
    logic     clr_we;
    logic     div_go;
    div_sel_t div_sel;
    logic     accept;
    logic     check;
    logic     set_oob;
    logic     fill_rd;
    logic     fill_wr_en;
    logic     occ_load;
    logic     out_load;
  } cmd_t;

  typedef struct packed {
    logic       cfg_hit;
    logic       clr_last;
    logic [1:0] in_kind;
    logic       in_neg;
    logic [1:0] kind;
    logic       div_done;
    logic       in_grid;
    logic       fill_last;
    logic       out_free;
  } sts_t;

endpackage

// ===== src/ogprm_div.sv =====
// Restoring radix-2 divider, one quotient bit per cycle.
// Depends on ogprm_pkg.
module ogprm_div (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           abort,
  input  logic                           go,
  input  logic [ogprm_pkg::DVD_W-1:0]    dividend,
  input  logic [ogprm_pkg::CFG_W-1:0]    divisor,
  output logic                           done,
  output logic [ogprm_pkg::DVD_W-1:0]    quotient
);
  import ogprm_pkg::*;

  localparam int CNT_W = $clog2(DVD_W);

  logic             busy;
  logic [CNT_W-1:0] cnt;
  logic [DVD_W-1:0] dvd;
  logic [DVD_W-1:0] quo;
  logic [CFG_W-1:0] dvs;
  logic [CFG_W-1:0] rem;
  logic [CFG_W:0]   shifted;
  logic             ge;
  logic [CFG_W-1:0] rem_next;

  always_comb begin
    shifted  = {rem, dvd[DVD_W-1]};
    ge       = shifted >= {1'b0, dvs};
    rem_next = ge ? CFG_W'(shifted - {1'b0, dvs}) : shifted[CFG_W-1:0];
    quotient = {quo[DVD_W-2:0], ge};
    done     = busy && (cnt == CNT_W'(DVD_W - 1));
  end

  always_ff @(posedge clk) begin
    if (rst || abort) begin
      busy <= 1'b0;
      cnt  <= '0;
    end else if (!busy) begin
      if (go) begin
        busy <= 1'b1;
        cnt  <= '0;
      end
    end else begin
      cnt <= CNT_W'(cnt + 1'b1);
      if (done) begin
        busy <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!busy) begin
      dvd <= dividend;
      dvs <= divisor;
      rem <= '0;
      quo <= '0;
    end else begin
      dvd <= {dvd[DVD_W-2:0], 1'b0};
      rem <= rem_next;
      quo <= quotient;
    end
  end

endmodule

// ===== src/ogprm_dp.sv =====
// Datapath: config registers, item registers, grid memory, divider and output word.
// Depends on ogprm_pkg and ogprm_div.
module ogprm_dp #(
  parameter int MAX_COLUMNS = ogprm_pkg::DEF_MAX_COLUMNS,
  parameter int MAX_ROWS    = ogprm_pkg::DEF_MAX_ROWS
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [ogprm_pkg::ADDR_W-1:0]   paddr,
  input  logic [ogprm_pkg::DATA_W-1:0]   pwdata,
  output logic [ogprm_pkg::DATA_W-1:0]   prdata,
  input  ogprm_pkg::in_word_t            in_data,
  input  logic                           out_stall,
  output logic                           out_valid,
  output ogprm_pkg::out_word_t           out_data,
  input  ogprm_pkg::cmd_t                cmd,
  output ogprm_pkg::sts_t                sts
);
  import ogprm_pkg::*;

  localparam int RA_W   = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
  localparam int COLC_W = $clog2(MAX_COLUMNS + 1);
  localparam int ROWC_W = $clog2(MAX_ROWS + 1);

  function automatic logic [CFG_W-1:0] clamp_coord(logic signed [COORD_W-1:0] v,
                                                   logic [CFG_W-1:0] hi);
    logic [CFG_W-1:0] r;
    if (v[COORD_W-1]) begin
      r = '0;
    end else if (v[COORD_W-2:0] > (COORD_W-1)'(hi)) begin
      r = hi;
    end else begin
      r = v[CFG_W-1:0];
    end
    return r;
  endfunction

  // config registers
  logic [CFG_W-1:0] win_w, win_h, cell_w, cell_h;
  logic [CFG_W-1:0] wdat;
  logic             cfg_hit;

  assign wdat    = pwdata[CFG_W-1:0];
  assign cfg_hit = psel && penable && pwrite && (wdat != '0);

  always_ff @(posedge clk) begin
    if (rst) begin
      win_w  <= RST_WIN_W;
      win_h  <= RST_WIN_H;
      cell_w <= RST_CELL_W;
      cell_h <= RST_CELL_H;
    end else if (cfg_hit) begin
      unique case (paddr[ADDR_W-1:2])
        REG_WIN_W:  win_w  <= wdat;
        REG_WIN_H:  win_h  <= wdat;
        REG_CELL_W: cell_w <= wdat;
        REG_CELL_H: cell_h <= wdat;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[ADDR_W-1:2])
      REG_WIN_W:  prdata = DATA_W'(win_w);
      REG_WIN_H:  prdata = DATA_W'(win_h);
      REG_CELL_W: prdata = DATA_W'(cell_w);
      REG_CELL_H: prdata = DATA_W'(cell_h);
    endcase
  end

  // item registers; coordinates are replaced by their cell indices
  logic [1:0]        item_kind;
  logic [DVD_W-1:0]  x0, y0, x1, y1;
  logic [COLC_W-1:0] cols;
  logic [ROWC_W-1:0] rows;
  logic [CFG_W-1:0]  xa, xb, ya, yb;

  always_comb begin
    xa = clamp_coord(in_data.x_first,  win_w);
    xb = clamp_coord(in_data.x_second, win_w);
    ya = clamp_coord(in_data.y_first,  win_h);
    yb = clamp_coord(in_data.y_second, win_h);
  end

  // divider
  logic [DVD_W-1:0] dvd;
  logic [CFG_W-1:0] dvs;
  logic [DVD_W-1:0] quo;
  logic             div_done;
  logic [CFG_W:0]   cols_num, rows_num;

  assign cols_num = {1'b0, win_w} + {1'b0, cell_w} - 1'b1;
  assign rows_num = {1'b0, win_h} + {1'b0, cell_h} - 1'b1;

  always_comb begin
    unique case (cmd.div_sel)
      DIV_COLS: begin dvd = DVD_W'(cols_num); dvs = cell_w; end
      DIV_ROWS: begin dvd = DVD_W'(rows_num); dvs = cell_h; end
      DIV_X0:   begin dvd = x0; dvs = cell_w; end
      DIV_Y0:   begin dvd = y0; dvs = cell_h; end
      DIV_X1:   begin dvd = x1; dvs = cell_w; end
      DIV_Y1:   begin dvd = y1; dvs = cell_h; end
      default:  begin dvd = x0; dvs = cell_w; end
    endcase
  end

  ogprm_div u_div (
    .clk      (clk),
    .rst      (rst),
    .abort    (cfg_hit),
    .go       (cmd.div_go),
    .dividend (dvd),
    .divisor  (dvs),
    .done     (div_done),
    .quotient (quo)
  );

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      item_kind <= in_data.kind;
      if (in_data.kind == KIND_RECT) begin
        x0 <= DVD_W'((xa < xb) ? xa : xb);
        x1 <= DVD_W'((xa < xb) ? xb : xa);
        y0 <= DVD_W'((ya < yb) ? ya : yb);
        y1 <= DVD_W'((ya < yb) ? yb : ya);
      end else begin
        x0 <= in_data.x_first[DVD_W-1:0];
        y0 <= in_data.y_first[DVD_W-1:0];
      end
    end else if (div_done) begin
      unique case (cmd.div_sel)
        DIV_COLS: cols <= (quo > DVD_W'(MAX_COLUMNS)) ? COLC_W'(MAX_COLUMNS)
                                                    : quo[COLC_W-1:0];
        DIV_ROWS: rows <= (quo > DVD_W'(MAX_ROWS)) ? ROWC_W'(MAX_ROWS)
                                                 : quo[ROWC_W-1:0];
        DIV_X0:   x0 <= quo;
        DIV_Y0:   y0 <= quo;
        DIV_X1:   x1 <= quo;
        DIV_Y1:   y1 <= quo;
        default:  x0 <= x0;
      endcase
    end
  end

  // grid bounds, row span and column mask
  logic [DVD_W-1:0]       cols_m1, rows_m1, c_hi, y1c;
  logic                   in_grid;
  logic [MAX_COLUMNS-1:0] mask_next, mask;
  logic [RA_W-1:0]        fill_row, r_last, r_last_next;

  always_comb begin
    cols_m1 = DVD_W'(cols) - 1'b1;
    rows_m1 = DVD_W'(rows) - 1'b1;
    in_grid = (x0 < DVD_W'(cols)) && (y0 < DVD_W'(rows));
    y1c     = (y1 > rows_m1) ? rows_m1 : y1;
    if (item_kind == KIND_RECT) begin
      c_hi        = (x1 > cols_m1) ? cols_m1 : x1;
      r_last_next = y1c[RA_W-1:0];
    end else begin
      c_hi        = x0;
      r_last_next = y0[RA_W-1:0];
    end
    for (int c = 0; c < MAX_COLUMNS; c++) begin
      mask_next[c] = (DVD_W'(c) >= x0) && (DVD_W'(c) <= c_hi);
    end
  end

  // grid memory; a fill reads row r while writing row r-1
  logic [MAX_COLUMNS-1:0] grid [MAX_ROWS];
  logic [MAX_COLUMNS-1:0] rd_data;
  logic [MAX_COLUMNS-1:0] mem_wd;
  logic [RA_W-1:0]        mem_wa, clr_addr, wr_row;
  logic                   mem_we, wr_pend, clr_last;

  assign clr_last = clr_addr == RA_W'(MAX_ROWS - 1);
  assign mem_we   = cmd.clr_we || wr_pend;
  assign mem_wa   = cmd.clr_we ? clr_addr : wr_row;
  assign mem_wd   = cmd.clr_we ? '0 : (rd_data | mask);

  always_ff @(posedge clk) begin
    if (mem_we) begin
      grid[mem_wa] <= mem_wd;
    end
    if (cmd.fill_rd) begin
      rd_data <= grid[fill_row];
    end
  end

  always_ff @(posedge clk) begin
    if (rst || cfg_hit) begin
      clr_addr <= '0;
    end else if (cmd.clr_we) begin
      clr_addr <= clr_last ? '0 : RA_W'(clr_addr + 1'b1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_pend <= 1'b0;
    end else begin
      wr_pend <= cmd.fill_rd && cmd.fill_wr_en;
    end
  end

  always_ff @(posedge clk) begin
    wr_row <= fill_row;
    if (cmd.check) begin
      mask     <= mask_next;
      fill_row <= y0[RA_W-1:0];
      r_last   <= r_last_next;
    end else if (cmd.fill_rd) begin
      fill_row <= RA_W'(fill_row + 1'b1);
    end
  end

  // result and output word
  logic res_occ, res_st;

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      res_occ <= 1'b0;
      res_st  <= (in_data.kind == KIND_POINT || in_data.kind == KIND_QUERY) && sts.in_neg;
    end else begin
      if (cmd.set_oob) begin
        res_st <= 1'b1;
      end
      if (cmd.occ_load) begin
        res_occ <= |(rd_data & mask);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_data.occupied <= res_occ;
      out_data.status   <= res_st;
    end
  end

  always_comb begin
    sts.cfg_hit   = cfg_hit;
    sts.clr_last  = clr_last;
    sts.in_kind   = in_data.kind;
    sts.in_neg    = in_data.x_first[COORD_W-1] || in_data.y_first[COORD_W-1];
    sts.kind      = item_kind;
    sts.div_done  = div_done;
    sts.in_grid   = in_grid;
    sts.fill_last = fill_row == r_last;
    sts.out_free  = !out_valid || !out_stall;
  end

endmodule

// ===== src/ogprm_ctrl.sv =====
// Controller state machine: clear pass, grid sizing, item sequencing.
// Depends on ogprm_pkg.
module ogprm_ctrl (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_stall,
  input  ogprm_pkg::sts_t  sts,
  output ogprm_pkg::cmd_t  cmd
);
  import ogprm_pkg::*;

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ST_CLEAR:    if (sts.clr_last) state_next = ST_DIV_COLS;
      ST_DIV_COLS: if (sts.div_done) state_next = ST_DIV_ROWS;
      ST_DIV_ROWS: if (sts.div_done) state_next = ST_IDLE;
      ST_IDLE: begin
        if (in_valid) begin
          if (sts.in_kind == KIND_NOP) begin
            state_next = ST_RESULT;
          end else if (sts.in_kind != KIND_RECT && sts.in_neg) begin
            state_next = ST_RESULT;
          end else begin
            state_next = ST_DIV_X0;
          end
        end
      end
      ST_DIV_X0:   if (sts.div_done) state_next = ST_DIV_Y0;
      ST_DIV_Y0: begin
        if (sts.div_done) begin
          state_next = (sts.kind == KIND_RECT) ? ST_DIV_X1 : ST_CHECK;
        end
      end
      ST_DIV_X1:   if (sts.div_done) state_next = ST_DIV_Y1;
      ST_DIV_Y1:   if (sts.div_done) state_next = ST_CHECK;
      ST_CHECK:    state_next = sts.in_grid ? ST_FILL : ST_RESULT;
      ST_FILL:     if (sts.fill_last) state_next = ST_FILL_END;
      ST_FILL_END: state_next = ST_RESULT;
      ST_RESULT:   if (sts.out_free) state_next = ST_IDLE;
    endcase
    if (sts.cfg_hit) begin
      state_next = ST_CLEAR;
    end
  end

  always_comb begin
    cmd         = '0;
    cmd.div_sel = DIV_COLS;
    unique case (state)
      ST_CLEAR:    cmd.clr_we = 1'b1;
      ST_DIV_COLS: begin cmd.div_go = 1'b1; cmd.div_sel = DIV_COLS; end
      ST_DIV_ROWS: begin cmd.div_go = 1'b1; cmd.div_sel = DIV_ROWS; end
      ST_IDLE:     cmd.accept = in_valid;
      ST_DIV_X0:   begin cmd.div_go = 1'b1; cmd.div_sel = DIV_X0; end
      ST_DIV_Y0:   begin cmd.div_go = 1'b1; cmd.div_sel = DIV_Y0; end
      ST_DIV_X1:   begin cmd.div_go = 1'b1; cmd.div_sel = DIV_X1; end
      ST_DIV_Y1:   begin cmd.div_go = 1'b1; cmd.div_sel = DIV_Y1; end
      ST_CHECK: begin
        cmd.check   = 1'b1;
        cmd.set_oob = !sts.in_grid && (sts.kind != KIND_RECT);
      end
      ST_FILL: begin
        cmd.fill_rd    = 1'b1;
        cmd.fill_wr_en = sts.kind != KIND_QUERY;
      end
      ST_FILL_END: cmd.occ_load = sts.kind == KIND_QUERY;
      ST_RESULT:   cmd.out_load = sts.out_free;
    endcase
  end

  assign in_stall = state != ST_IDLE;

endmodule

// ===== src/occupancy_grid_point_rect_marker_unit.sv =====
// Occupancy grid marker: a MAX_ROWS x MAX_COLUMNS bit grid over a pixel window. Every
// item returns one word unless a nonzero register write aborts it. A point or query
// needs two cell-index divisions on the shared serial divider; a rectangle needs four
// divisions, then one grid row read-modify-write per cycle through the memory's read and
// write ports. After reset and after every nonzero register write the grid is cleared
// and its size recomputed; no item is accepted meanwhile. A result may wait in the
// output register.
// Depends on ogprm_pkg, ogprm_ctrl, ogprm_dp and the assertion macro header.
`include "occupancy_grid_point_rect_marker_unit_macros.svh"

module occupancy_grid_point_rect_marker_unit #(
  parameter int MAX_COLUMNS = ogprm_pkg::DEF_MAX_COLUMNS,
  parameter int MAX_ROWS    = ogprm_pkg::DEF_MAX_ROWS
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [ogprm_pkg::ADDR_W-1:0]   paddr,
  input  logic [ogprm_pkg::DATA_W-1:0]   pwdata,
  output logic [ogprm_pkg::DATA_W-1:0]   prdata,
  output logic                           pready,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  ogprm_pkg::in_word_t            in_data,
  output logic                           out_valid,
  input  logic                           out_stall,
  output ogprm_pkg::out_word_t           out_data
);
  import ogprm_pkg::*;

  cmd_t cmd;
  sts_t sts;

  assign pready = 1'b1;

  ogprm_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .sts      (sts),
    .cmd      (cmd)
  );

  ogprm_dp #(
    .MAX_COLUMNS (MAX_COLUMNS),
    .MAX_ROWS    (MAX_ROWS)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .psel      (psel),
    .penable   (penable),
    .pwrite    (pwrite),
    .paddr     (paddr),
    .pwdata    (pwdata),
    .prdata    (prdata),
    .in_data   (in_data),
    .out_stall (out_stall),
    .out_valid (out_valid),
    .out_data  (out_data),
    .cmd       (cmd),
    .sts       (sts)
  );

  `OGPRM_ASSERT_NEXT(a_busy_after_accept, clk, rst, in_valid && !in_stall, in_stall)
  `OGPRM_ASSERT_NOW(a_no_accept_in_clear, clk, rst, cmd.clr_we, in_stall)
  `OGPRM_ASSERT_NOW(a_out_load_free, clk, rst, cmd.out_load, !out_valid || !out_stall)

endmodule
